// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl of the slot allocator
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fsla_pkg.sv =====
// shared types and constants for the free list slot allocator
// no dependencies; imported by the link memory and the top level
package fsla_pkg;

   localparam int unsigned MAX_SLOTS_DEFAULT = 256;

   localparam int unsigned ACTION_W = 1;
   localparam int unsigned SLOT_W   = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 9;
   localparam int unsigned POOL_W   = 9;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EMPTY       = 2'd1,
      STATUS_NOT_IN_POOL = 2'd2
   } status_type;

   typedef enum logic [ACTION_W-1:0] {
      ACTION_TAKE    = 1'b0,
      ACTION_RECYCLE = 1'b1
   } action_type;

endpackage

// ===== rtl/free_list_slot_allocator.sv =====
// free list slot allocator: lifo free list held in a link memory plus a fill mark
// recycle, failed take and fill-mark take answer in the cycle after the beat;
// a take from the free list answers via ST_LINK, after the registered link memory read
// one beat per cycle unless the response stalls; a pop from the list stalls requests in ST_LINK
// reset (synchronous): list empty, fill mark 0, count 0, pool size min(256, MAX_SLOTS)
// depends on fsla_pkg, fsla_link_mem and assert_macros.svh
`include "assert_macros.svh"

module free_list_slot_allocator
   import fsla_pkg::*;
#(
   parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_write_en,
   input  logic [POOL_W-1:0]   csr_write_data,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [SLOT_W-1:0]   req_slot_index,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SLOT_W-1:0]   rsp_granted_slot,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_in_use_count
);

   // pointer width holds every slot plus the end-of-list mark
   localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
   localparam int unsigned PTR_W = $clog2(MAX_SLOTS + 1);
   // common width for compares against the 9-bit pool size and 8-bit slot
   localparam int unsigned CMP_W = (PTR_W > POOL_W) ? PTR_W : POOL_W;
   localparam int unsigned POOL_RST = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
   localparam logic [PTR_W-1:0] END_MARK = PTR_W'(MAX_SLOTS);

   typedef enum logic {
      ST_IDLE,
      ST_LINK
   } state_type;

   state_type           state_ff,      state_in;
   logic [PTR_W-1:0]    free_head_ff,  free_head_in;
   logic [PTR_W-1:0]    fill_mark_ff,  fill_mark_in;
   logic [PTR_W-1:0]    taken_ff,      taken_in;
   logic [POOL_W-1:0]   pool_ff,       pool_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [PTR_W-1:0]    rsp_grant_ff,  rsp_grant_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [PTR_W-1:0]    rsp_count_ff,  rsp_count_in;

   logic                req_fire;
   logic                rsp_fire;
   logic [CMP_W-1:0]    pool_ext;
   logic [CMP_W-1:0]    size_ext;
   logic [PTR_W-1:0]    size;
   logic [CMP_W-1:0]    slot_ext;
   logic                slot_in_pool;
   logic                head_listed;
   logic [PTR_W-1:0]    taken_inc;
   logic [PTR_W-1:0]    taken_dec;
   logic [CMP_W-1:0]    grant_ext;
   logic [CMP_W-1:0]    count_ext;

   // link memory ports
   logic                link_wr_en;
   logic [IDX_W-1:0]    link_wr_addr;
   logic                link_rd_en;
   logic [PTR_W-1:0]    link_rd_data;

   // stall while a pop waits on the link read, or while the output beat is held
   assign req_stall = (state_ff == ST_LINK) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;

   // effective pool size, clamped to the built depth
   assign pool_ext     = CMP_W'(pool_ff);
   assign size_ext     = (pool_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : pool_ext;
   assign size         = size_ext[PTR_W-1:0];
   assign slot_ext     = CMP_W'(req_slot_index);
   assign slot_in_pool = slot_ext < size_ext;
   assign head_listed  = free_head_ff < END_MARK;

   // saturating count steps
   assign taken_inc = (taken_ff < END_MARK) ? taken_ff + 1'b1 : taken_ff;
   assign taken_dec = (taken_ff != '0) ? taken_ff - 1'b1 : taken_ff;

   // a recycle links the slot to the current head; a pop reads the head's link
   assign link_wr_en   = req_fire && (req_action == ACTION_RECYCLE) && slot_in_pool;
   assign link_wr_addr = slot_ext[IDX_W-1:0];
   assign link_rd_en   = req_fire && (req_action == ACTION_TAKE) && head_listed;

   fsla_link_mem #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (free_head_ff),
      .rd_en   (link_rd_en),
      .rd_addr (free_head_ff[IDX_W-1:0]),
      .rd_data (link_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      fill_mark_in  = fill_mark_ff;
      taken_in      = taken_ff;
      pool_in       = csr_write_en ? csr_write_data : pool_ff;
      // output beat is kept until the far side takes it
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_grant_in  = rsp_grant_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACTION_TAKE) begin
                  if (head_listed) begin
                     // pop: finish once the link comes back
                     state_in = ST_LINK;
                  end else if (fill_mark_ff < size) begin
                     // never-issued slot, ascending order
                     fill_mark_in  = fill_mark_ff + 1'b1;
                     taken_in      = taken_inc;
                     rsp_valid_in  = 1'b1;
                     rsp_grant_in  = fill_mark_ff;
                     rsp_status_in = STATUS_OK;
                     rsp_count_in  = taken_inc;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_grant_in  = '0;
                     rsp_status_in = STATUS_EMPTY;
                     rsp_count_in  = taken_ff;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_grant_in = '0;
                  if (slot_in_pool) begin
                     free_head_in  = slot_ext[PTR_W-1:0];
                     taken_in      = taken_dec;
                     rsp_status_in = STATUS_OK;
                     rsp_count_in  = taken_dec;
                  end else begin
                     rsp_status_in = STATUS_NOT_IN_POOL;
                     rsp_count_in  = taken_ff;
                  end
               end
            end
         end
         ST_LINK: begin
            // head is unchanged during the read, so it is the granted slot
            state_in      = ST_IDLE;
            free_head_in  = (link_rd_data > END_MARK) ? END_MARK : link_rd_data;
            taken_in      = taken_inc;
            rsp_valid_in  = 1'b1;
            rsp_grant_in  = free_head_ff;
            rsp_status_in = STATUS_OK;
            rsp_count_in  = taken_inc;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= END_MARK;
         fill_mark_ff <= '0;
         taken_ff     <= '0;
         pool_ff      <= POOL_W'(POOL_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_mark_ff <= fill_mark_in;
         taken_ff     <= taken_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset needed
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // fixed-width result fields, truncated as the interface defines them
   assign grant_ext        = CMP_W'(rsp_grant_ff);
   assign count_ext        = CMP_W'(rsp_count_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = grant_ext[SLOT_W-1:0];
   assign rsp_status       = rsp_status_ff;
   assign rsp_in_use_count = count_ext[COUNT_W-1:0];

   // checks on the allocator's own bookkeeping
   `ASSERT_NEXT(a_link_one_cycle, clock, reset, state_ff == ST_LINK, state_ff == ST_IDLE, "link wait longer than one cycle")
   `ASSERT_NEXT(a_beat_answered, clock, reset, req_fire, rsp_valid_ff || (state_ff == ST_LINK), "accepted beat left without answer")
   `ASSERT_ALWAYS(a_head_in_range, clock, reset, free_head_ff <= END_MARK, "free head beyond end mark")
   `ASSERT_ALWAYS(a_count_in_range, clock, reset, taken_ff <= END_MARK, "in-use count beyond pool depth")
   `ASSERT_ALWAYS(a_fill_in_range, clock, reset, fill_mark_ff <= END_MARK, "fill mark beyond pool depth")

endmodule

// ===== rtl/fsla_link_mem.sv =====
// link memory of the free list: one write port, one read port, registered read
// depends on fsla_pkg for the default depth
module fsla_link_mem
   import fsla_pkg::*;
#(
   parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEFAULT,
   localparam int unsigned IDX_W    = $clog2(MAX_SLOTS),
   localparam int unsigned PTR_W    = $clog2(MAX_SLOTS + 1)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [PTR_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [PTR_W-1:0] rd_data
);

   logic [PTR_W-1:0] link_mem [MAX_SLOTS];
   logic [PTR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
